### hw/rtl/wft_pkg.sv
// shared types and constants for the winograd f(4,3) transform unit
// no dependencies; imported by every module of the block
package wft_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int RES_W      = DATA_WIDTH + 5;
  localparam int CNT_W      = 3;
  localparam int NUM_LANES  = 6;

  // filter numerator magnitudes stay at or below 7 * 2^(DATA_WIDTH-1) plus rounding bias
  localparam int DIV_W  = DATA_WIDTH + 2;
  localparam int K6     = DIV_W + 3;
  localparam int K24    = DIV_W + 5;
  localparam int PROD_W = 2 * DIV_W + 1;

  localparam logic [DIV_W:0] RECIP_6  = (DIV_W + 1)'(((64'd1 << K6) + 64'd5) / 64'd6);
  localparam logic [DIV_W:0] RECIP_24 = (DIV_W + 1)'(((64'd1 << K24) + 64'd23) / 64'd24);

  localparam logic [1:0] CMD_FILTER = 2'd0;
  localparam logic [1:0] CMD_INPUT  = 2'd1;
  localparam logic [1:0] CMD_OUTPUT = 2'd2;

  localparam logic [CNT_W-1:0] COUNT_NONE = 3'd0;
  localparam logic [CNT_W-1:0] COUNT_FOUR = 3'd4;
  localparam logic [CNT_W-1:0] COUNT_SIX  = 3'd6;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [RES_W-1:0]      res_t;

  typedef enum logic [1:0] {
    DIV_NONE = 2'd0,
    DIV_BY4  = 2'd1,
    DIV_BY6  = 2'd2,
    DIV_BY24 = 2'd3
  } div_mode_t;

  typedef struct packed {
    res_t      num;
    div_mode_t mode;
    logic      neg;
  } lane_req_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
  } pipe_ctrl_t;

endpackage

### hw/rtl/wft_premix.sv
// forms the exact numerator, divide mode and sign for each result lane
// depends on wft_pkg
module wft_premix (
  input  logic [1:0]                 command,
  input  wft_pkg::data_t             vals [wft_pkg::NUM_LANES],
  output wft_pkg::lane_req_t         req  [wft_pkg::NUM_LANES],
  output logic [wft_pkg::CNT_W-1:0]  count
);
  import wft_pkg::*;

  res_t s [NUM_LANES];
  res_t even;
  res_t quad;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      s[i] = {{(RES_W - DATA_WIDTH){vals[i][DATA_WIDTH-1]}}, vals[i]};
    end
    even = s[0] + s[2];
    quad = s[0] + (s[2] <<< 2);
    for (int i = 0; i < NUM_LANES; i++) begin
      req[i] = '{num: '0, mode: DIV_NONE, neg: 1'b0};
    end
    count = COUNT_NONE;
    case (command)
      CMD_FILTER: begin
        req[0] = '{num: s[0],               mode: DIV_BY4,  neg: 1'b0};
        req[1] = '{num: even + s[1],        mode: DIV_BY6,  neg: 1'b1};
        req[2] = '{num: even - s[1],        mode: DIV_BY6,  neg: 1'b1};
        req[3] = '{num: quad + (s[1] <<< 1), mode: DIV_BY24, neg: 1'b0};
        req[4] = '{num: quad - (s[1] <<< 1), mode: DIV_BY24, neg: 1'b0};
        req[5] = '{num: s[2],               mode: DIV_NONE, neg: 1'b0};
        count  = COUNT_SIX;
      end
      CMD_INPUT: begin
        req[0].num = (s[0] <<< 2) - (s[2] <<< 2) - s[2] + s[4];
        req[1].num = s[3] + s[4] - ((s[1] + s[2]) <<< 2);
        req[2].num = ((s[1] - s[2]) <<< 2) + (s[4] - s[3]);
        req[3].num = ((s[3] - s[1]) <<< 1) + (s[4] - s[2]);
        req[4].num = ((s[1] - s[3]) <<< 1) + (s[4] - s[2]);
        req[5].num = (s[1] <<< 2) - (s[3] <<< 2) - s[3] + s[5];
        count      = COUNT_SIX;
      end
      CMD_OUTPUT: begin
        req[0].num = s[0] + s[1] + s[2] + s[3] + s[4];
        req[1].num = (s[1] - s[2]) + ((s[3] - s[4]) <<< 1);
        req[2].num = (s[1] + s[2]) + ((s[3] + s[4]) <<< 2);
        req[3].num = (s[1] - s[2]) + ((s[3] - s[4]) <<< 3) + s[5];
        count      = COUNT_FOUR;
      end
      default: begin
        count = COUNT_NONE;
      end
    endcase
  end

endmodule

### hw/rtl/wft_lane.sv
// one result lane: rounding divide by 4, 6 or 24 (or pass) in two stages
// depends on wft_pkg
module wft_lane (
  input  logic                clk,
  input  wft_pkg::pipe_ctrl_t ctrl,
  input  wft_pkg::lane_req_t  req,
  output wft_pkg::res_t       result
);
  import wft_pkg::*;

  // stage 1: magnitude plus half divisor
  div_mode_t        mode1_r;
  logic             neg1_r;
  logic [DIV_W-1:0] mag1_r;
  res_t             num1_r;
  res_t             result_r;

  res_t             abs_v;
  res_t             bias;
  res_t             biased;
  logic [DIV_W:0]   recip;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0] quot;
  res_t             quot_ext;
  res_t             result_nxt;

  always_comb begin
    abs_v = req.num[RES_W-1] ? -req.num : req.num;
    case (req.mode)
      DIV_BY4:  bias = RES_W'(2);
      DIV_BY6:  bias = RES_W'(3);
      DIV_BY24: bias = RES_W'(12);
      default:  bias = '0;
    endcase
    biased = abs_v + bias;
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      mode1_r <= req.mode;
      neg1_r  <= req.num[RES_W-1] ^ req.neg;
      mag1_r  <= biased[DIV_W-1:0];
      num1_r  <= req.num;
    end
  end

  // stage 2: reciprocal multiply, restore sign
  always_comb begin
    recip = (mode1_r == DIV_BY24) ? RECIP_24 : RECIP_6;
    prod  = PROD_W'(mag1_r) * PROD_W'(recip);
    case (mode1_r)
      DIV_BY4:  quot = mag1_r >> 2;
      DIV_BY6:  quot = DIV_W'(prod >> K6);
      DIV_BY24: quot = DIV_W'(prod >> K24);
      default:  quot = '0;
    endcase
    quot_ext = RES_W'(quot);
    if (mode1_r == DIV_NONE) begin
      result_nxt = num1_r;
    end else begin
      result_nxt = neg1_r ? -quot_ext : quot_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

### hw/rtl/winograd_f4_3_transform_unit.sv
// top level of the winograd f(4,3) 1-d transform unit
// depends on wft_pkg, wft_premix and wft_lane
//
// usage:
//   the input channel (in_valid/in_ready) takes one word per tile: a command
//   (filter, input or output transform) and six signed q8.8 elements
//   the result channel (out_valid/out_ready) returns one word per tile: six
//   signed q13.8 results and the count of meaningful results (6, 4 or 0)
//   six lanes work on the six result elements side by side; each lane has
//   a bias/magnitude stage and a reciprocal-multiply stage, and the output
//   register gathers the lanes together with the count
// throughput: 1 word per cycle while out_ready is high, set by the two-stage lane
//   pipeline; the lane multiplier (18 x 19 bits) sits alone in the second stage
// reset: rst_n low empties the pipeline, out_valid drops and in_ready rises
// stalls: when out_ready is low the result holds in the output register;
//   one more word can still enter the first stage before in_ready falls
module winograd_f4_3_transform_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_command,
  input  wft_pkg::data_t                in_value_0,
  input  wft_pkg::data_t                in_value_1,
  input  wft_pkg::data_t                in_value_2,
  input  wft_pkg::data_t                in_value_3,
  input  wft_pkg::data_t                in_value_4,
  input  wft_pkg::data_t                in_value_5,
  output logic                          out_valid,
  input  logic                          out_ready,
  output wft_pkg::res_t                 out_result_0,
  output wft_pkg::res_t                 out_result_1,
  output wft_pkg::res_t                 out_result_2,
  output wft_pkg::res_t                 out_result_3,
  output wft_pkg::res_t                 out_result_4,
  output wft_pkg::res_t                 out_result_5,
  output logic [wft_pkg::CNT_W-1:0]     out_result_count
);
  import wft_pkg::*;

  logic             v1_r;
  logic             v1_nxt;
  logic             v2_r;
  logic             v2_nxt;
  logic [CNT_W-1:0] count1_r;
  logic [CNT_W-1:0] count2_r;
  logic             adv1;
  logic             adv2;
  pipe_ctrl_t       ctrl;

  data_t            vals     [NUM_LANES];
  lane_req_t        req      [NUM_LANES];
  res_t             lane_res [NUM_LANES];
  logic [CNT_W-1:0] count;

  assign vals[0] = in_value_0;
  assign vals[1] = in_value_1;
  assign vals[2] = in_value_2;
  assign vals[3] = in_value_3;
  assign vals[4] = in_value_4;
  assign vals[5] = in_value_5;

  // pipeline advance: a stage loads when the stage after it has room
  assign adv2     = !v2_r || out_ready;
  assign adv1     = !v1_r || adv2;
  assign ctrl.ld1 = in_valid && adv1;
  assign ctrl.ld2 = v1_r && adv2;
  assign in_ready = adv1;
  assign v1_nxt   = adv1 ? in_valid : v1_r;
  assign v2_nxt   = adv2 ? v1_r : v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      count1_r <= count;
    end
    if (ctrl.ld2) begin
      count2_r <= count1_r;
    end
  end

  wft_premix u_premix (
    .command (in_command),
    .vals    (vals),
    .req     (req),
    .count   (count)
  );

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    wft_lane u_lane (
      .clk    (clk),
      .ctrl   (ctrl),
      .req    (req[g]),
      .result (lane_res[g])
    );
  end

  // merge: lane outputs and count form the result word
  assign out_valid        = v2_r;
  assign out_result_0     = lane_res[0];
  assign out_result_1     = lane_res[1];
  assign out_result_2     = lane_res[2];
  assign out_result_3     = lane_res[3];
  assign out_result_4     = lane_res[4];
  assign out_result_5     = lane_res[5];
  assign out_result_count = count2_r;

  a_stage1_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !(v2_r && !out_ready)) |=> v2_r)
    else $error("occupied first stage did not move to output");

  a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && !out_ready) |-> !in_ready)
    else $error("input accepted with full pipeline");

  a_count_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_count == COUNT_SIX || out_result_count == COUNT_FOUR ||
                   out_result_count == COUNT_NONE))
    else $error("bad result count");

  a_four_zero_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_count == COUNT_FOUR) |-> (out_result_4 == '0 && out_result_5 == '0))
    else $error("output transform left nonzero tail");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_count == COUNT_NONE) |-> (out_result_0 == '0 && out_result_3 == '0))
    else $error("unused command produced nonzero result");

endmodule

### tb/tb_winograd_f4_3_transform_unit.sv
// self-checking bench for winograd_f4_3_transform_unit: directed and random tiles for all commands
// predicts each result word with its own transform math; depends on wft_pkg and the unit rtl
module tb_winograd_f4_3_transform_unit;
  import wft_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD   = 60;
  localparam int SETTLE      = 8;

  typedef data_t [NUM_LANES-1:0] tile_vals_t;

  typedef struct packed {
    logic [CNT_W-1:0]     count;
    res_t [NUM_LANES-1:0] elem;
  } tile_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             in_command;
  data_t                  in_val [NUM_LANES];
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  res_t                   out_res [NUM_LANES];
  logic [CNT_W-1:0]       out_count;

  tile_result_t pending_results[$];
  int  errors     = 0;
  bit  quiet      = 1'b0;
  int  hold_req   = 0;
  int  hold_done  = 0;
  int  rx_wait    = 0;
  int  stuck      = 0;

  winograd_f4_3_transform_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_value_0       (in_val[0]),
    .in_value_1       (in_val[1]),
    .in_value_2       (in_val[2]),
    .in_value_3       (in_val[3]),
    .in_value_4       (in_val[4]),
    .in_value_5       (in_val[5]),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_0     (out_res[0]),
    .out_result_1     (out_res[1]),
    .out_result_2     (out_res[2]),
    .out_result_3     (out_res[3]),
    .out_result_4     (out_res[4]),
    .out_result_5     (out_res[5]),
    .out_result_count (out_count)
  );

  always #6 clk = ~clk;

  // nearest integer, ties away from zero
  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic tile_result_t transform_tile(logic [1:0] cmd, tile_vals_t vals);
    longint s [NUM_LANES];
    longint r [NUM_LANES];
    longint even, quad;
    tile_result_t res;
    for (int i = 0; i < NUM_LANES; i++) begin
      s[i] = $signed(vals[i]);
      r[i] = 0;
    end
    res.count = COUNT_NONE;
    case (cmd)
      CMD_FILTER: begin
        even = s[0] + s[2];
        quad = s[0] + 4 * s[2];
        r[0] = round_div(s[0], 4);
        r[1] = -round_div(even + s[1], 6);
        r[2] = -round_div(even - s[1], 6);
        r[3] = round_div(quad + 2 * s[1], 24);
        r[4] = round_div(quad - 2 * s[1], 24);
        r[5] = s[2];
        res.count = COUNT_SIX;
      end
      CMD_INPUT: begin
        r[0] = 4 * s[0] - 5 * s[2] + s[4];
        r[1] = s[3] + s[4] - 4 * (s[1] + s[2]);
        r[2] = 4 * (s[1] - s[2]) + (s[4] - s[3]);
        r[3] = 2 * (s[3] - s[1]) + (s[4] - s[2]);
        r[4] = 2 * (s[1] - s[3]) + (s[4] - s[2]);
        r[5] = 4 * s[1] - 5 * s[3] + s[5];
        res.count = COUNT_SIX;
      end
      CMD_OUTPUT: begin
        r[0] = s[0] + s[1] + s[2] + s[3] + s[4];
        r[1] = (s[1] - s[2]) + 2 * (s[3] - s[4]);
        r[2] = (s[1] + s[2]) + 4 * (s[3] + s[4]);
        r[3] = (s[1] - s[2]) + 8 * (s[3] - s[4]) + s[5];
        res.count = COUNT_FOUR;
      end
      default: res.count = COUNT_NONE;
    endcase
    for (int i = 0; i < NUM_LANES; i++) res.elem[i] = res_t'(r[i]);
    return res;
  endfunction

  function automatic tile_vals_t make_tile(int a, int b, int c, int d, int e, int f);
    tile_vals_t v;
    v[0] = data_t'(a);
    v[1] = data_t'(b);
    v[2] = data_t'(c);
    v[3] = data_t'(d);
    v[4] = data_t'(e);
    v[5] = data_t'(f);
    return v;
  endfunction

  // extremes come up often enough to hit the range limits of every lane
  function automatic data_t pick_value();
    case ($urandom_range(0, 9))
      0: return data_t'(16'h7FFF);
      1: return data_t'(16'h8000);
      2: return data_t'(0);
      3: return data_t'(-1);
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_command();
    if ($urandom_range(0, 15) == 0) return CMD_SPARE;
    case ($urandom_range(0, 2))
      0: return CMD_FILTER;
      1: return CMD_INPUT;
      default: return CMD_OUTPUT;
    endcase
  endfunction

  // one input word; valid stays high into the next call unless a gap is taken
  task automatic send_tile(input logic [1:0] cmd, input tile_vals_t vals);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    in_command <= cmd;
    for (int i = 0; i < NUM_LANES; i++) in_val[i] <= vals[i];
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(transform_tile(cmd, vals));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(int n);
    tile_vals_t v;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < NUM_LANES; i++) v[i] = pick_value();
      send_tile(pick_command(), v);
    end
  endtask

  task automatic test_directed_tiles();
    send_tile(CMD_FILTER, make_tile(0, 0, 0, 0, 0, 0));
    send_tile(CMD_FILTER, make_tile(32767, 32767, 32767, 0, 0, 0));
    send_tile(CMD_FILTER, make_tile(-32768, -32768, -32768, 0, 0, 0));
    send_tile(CMD_FILTER, make_tile(32767, -32768, 32767, 0, 0, 0));
    send_tile(CMD_FILTER, make_tile(-32768, 32767, -32768, 0, 0, 0));
    // rounding ties in each divisor, both signs
    send_tile(CMD_FILTER, make_tile(2, 0, 0, 0, 0, 0));
    send_tile(CMD_FILTER, make_tile(-2, 0, 0, 0, 0, 0));
    send_tile(CMD_FILTER, make_tile(3, 0, 0, 0, 0, 0));
    send_tile(CMD_FILTER, make_tile(-3, 0, 0, 0, 0, 0));
    send_tile(CMD_FILTER, make_tile(12, 0, 0, 0, 0, 0));
    send_tile(CMD_FILTER, make_tile(-12, 0, 0, 0, 0, 0));
    send_tile(CMD_FILTER, make_tile(0, 0, 3, 0, 0, 0));
    send_tile(CMD_FILTER, make_tile(0, 0, -3, 0, 0, 0));
    // upper elements must not reach the filter math
    send_tile(CMD_FILTER, make_tile(100, -7, 55, 32767, -32768, -1));
    send_tile(CMD_INPUT, make_tile(32767, 32767, 32767, 32767, 32767, 32767));
    send_tile(CMD_INPUT, make_tile(-32768, -32768, -32768, -32768, -32768, -32768));
    send_tile(CMD_INPUT, make_tile(32767, -32768, 32767, -32768, 32767, -32768));
    send_tile(CMD_INPUT, make_tile(-32768, 32767, -32768, 32767, -32768, 32767));
    send_tile(CMD_OUTPUT, make_tile(0, 32767, -32768, 32767, -32768, 32767));
    send_tile(CMD_OUTPUT, make_tile(0, -32768, 32767, -32768, 32767, -32768));
    send_tile(CMD_OUTPUT, make_tile(32767, 32767, 32767, 32767, 32767, 32767));
    send_tile(CMD_SPARE, make_tile(1234, -5, 32767, -32768, 77, -1));
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering, then everything drains
  task automatic test_output_backlog();
    hold_req++;
    send_random(40);
    wait_drained();
  endtask

  task automatic test_streaming(int n);
    quiet = 1'b1;
    send_random(n);
    wait_drained();
  endtask

  // receiver: random stall bursts, plus a long hold on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_done != hold_req) begin
      hold_done = hold_req;
      rx_wait   = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      rx_wait = $urandom_range(1, 14) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    tile_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result word with no tile pending, count %0d", $time, out_count);
      end else begin
        want = pending_results.pop_front();
        for (int i = 0; i < NUM_LANES; i++) begin
          if (out_res[i] !== want.elem[i]) begin
            errors++;
            $display("%0t: result_%0d expected %0d got %0d", $time, i,
                     $signed(want.elem[i]), $signed(out_res[i]));
          end
        end
        if (out_count !== want.count) begin
          errors++;
          $display("%0t: result_count expected %0d got %0d", $time, want.count, out_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck = 0;
      end else begin
        stuck++;
        if (stuck >= STALL_LIMIT) begin
          $display("TEST FAILED");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = CMD_FILTER;
    for (int i = 0; i < NUM_LANES; i++) in_val[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_tiles();
    send_random(300);
    wait_drained();
    test_output_backlog();
    send_random(280);
    test_streaming(60);

    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/wft_pkg.sv
hw/rtl/wft_premix.sv
hw/rtl/wft_lane.sv
hw/rtl/winograd_f4_3_transform_unit.sv
tb/tb_winograd_f4_3_transform_unit.sv
